FILE: sv/capsule_capsule_overlap_test_assert.svh
// ----------------------------------------------------------------------------
// Capsule overlap test assertion macros
// Concurrent checks on clk, disabled while rst_n is low; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef CAPSULE_CAPSULE_OVERLAP_TEST_ASSERT_SVH
`define CAPSULE_CAPSULE_OVERLAP_TEST_ASSERT_SVH
`ifndef SYNTH
`define CCOT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("capsule overlap test: check failed");
`define CCOT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("capsule overlap test: check failed");
`else
`define CCOT_ASSERT(label, prop)
`define CCOT_ASSERT_IMP(label, ante, cons)
`endif
`endif

FILE: sv/ccot_pkg.sv
// ----------------------------------------------------------------------------
// Capsule overlap test package
// Word types, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package ccot_pkg;

  localparam int COORD_W   = 16;
  localparam int RAD_W     = 15;
  localparam int FRAC_W    = 16;
  localparam int DIST_W    = 34;
  localparam int CFG_IDX_W = 3;

  localparam logic [FRAC_W:0] FRAC_ONE = {1'b1, {FRAC_W{1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_START_X = 3'd0,
    CFG_OWN_START_Y = 3'd1,
    CFG_OWN_START_Z = 3'd2,
    CFG_OWN_END_X   = 3'd3,
    CFG_OWN_END_Y   = 3'd4,
    CFG_OWN_END_Z   = 3'd5,
    CFG_OWN_RADIUS  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] other_start_x;
    logic signed [COORD_W-1:0] other_start_y;
    logic signed [COORD_W-1:0] other_start_z;
    logic signed [COORD_W-1:0] other_end_x;
    logic signed [COORD_W-1:0] other_end_y;
    logic signed [COORD_W-1:0] other_end_z;
    logic [RAD_W-1:0]          other_radius;
  } in_word_t;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] dist_sq;
    logic [FRAC_W:0]   frac_other;
    logic [FRAC_W:0]   frac_own;
  } out_word_t;

endpackage

FILE: sv/ccot_div.sv
// ----------------------------------------------------------------------------
// Capsule overlap test divider
// Restoring divider, one quotient bit per register stage. Expects rem_i < den_i.
// ----------------------------------------------------------------------------
module ccot_div #(
  parameter int W     = 35,
  parameter int STEPS = 16
) (
  input  logic             clk,
  input  logic [W-1:0]     rem_i,
  input  logic [STEPS-1:0] low_i,
  input  logic [W-1:0]     den_i,
  output logic [STEPS-1:0] quo_o
);

  logic [W-1:0]     rem_r [STEPS-1];
  logic [STEPS-1:0] low_r [STEPS-1];
  logic [W-1:0]     den_r [STEPS-1];
  logic [STEPS-1:0] quo_r [STEPS];

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    logic [W-1:0]     rem_in;
    logic [W-1:0]     den_in;
    logic [STEPS-1:0] low_in;
    logic [STEPS-1:0] quo_in;
    logic [W-1:0]     rem_nxt;
    logic             take;

    if (j == 0) begin : g_first
      assign rem_in = rem_i;
      assign den_in = den_i;
      assign low_in = low_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign low_in = low_r[j-1];
      assign quo_in = quo_r[j-1];
    end

    assign rem_nxt = {rem_in[W-2:0], low_in[STEPS-1]};
    assign take    = (rem_nxt >= den_in);

    always_ff @(posedge clk) begin
      quo_r[j] <= {quo_in[STEPS-2:0], take};
    end

    if (j < STEPS-1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[j] <= take ? rem_nxt - den_in : rem_nxt;
        low_r[j] <= {low_in[STEPS-2:0], 1'b0};
        den_r[j] <= den_in;
      end
    end
  end

  assign quo_o = quo_r[STEPS-1];

endmodule

FILE: sv/capsule_capsule_overlap_test.sv
// ----------------------------------------------------------------------------
// Capsule against capsule overlap test
// Closest points between two capsule axes, squared distance and hit flag.
// ----------------------------------------------------------------------------
// Usage:
//   Load the stored capsule through the cfg_ port (cfg_we, cfg_index,
//   cfg_wdata); index order is start x/y/z, end x/y/z, radius. Write only while
//   no word is in flight.
//   Present a tested capsule on in_word with start high; it is taken at any
//   edge where start is high and busy is low. busy stays low, so one word can
//   be taken every cycle.
//   Each word gives one result word on out_word, marked by out_valid for one
//   cycle. Results leave in order, one per cycle at most; the receiver cannot
//   stall and needs none.
//   The path runs through two ranks of 16-stage restoring dividers (segment
//   parameter on the tested axis, then the parameter recompute beside the
//   stored axis parameter), plus eleven stages of products, sums and compares.
//   Reset clears the stored capsule to zero and drops every word in flight.
// ----------------------------------------------------------------------------
`include "capsule_capsule_overlap_test_assert.svh"

module capsule_capsule_overlap_test (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  ccot_pkg::in_word_t   in_word,
  output logic                 out_valid,
  output ccot_pkg::out_word_t  out_word,
  input  logic                 cfg_we,
  input  logic [ccot_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ccot_pkg::COORD_W-1:0]   cfg_wdata
);

  localparam int LATENCY = 43;
  localparam int FW      = ccot_pkg::FRAC_W;

  typedef struct packed {
    logic             valid;
    logic [2:0][16:0] d1;
    logic [2:0][16:0] d2;
    logic [2:0][16:0] r;
    logic [15:0]      rs;
    logic [33:0]      a;
    logic [33:0]      e;
    logic [35:0]      b;
    logic [35:0]      c;
    logic [35:0]      f;
    logic             s_div;
    logic [FW:0]      s_val;
    logic             t_div;
    logic [FW:0]      t_val;
  } item_t;

  // stored capsule
  logic signed [15:0] own_start_x_r, own_start_y_r, own_start_z_r;
  logic signed [15:0] own_end_x_r, own_end_y_r, own_end_z_r;
  logic [14:0]        own_radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_start_x_r <= '0;
      own_start_y_r <= '0;
      own_start_z_r <= '0;
      own_end_x_r   <= '0;
      own_end_y_r   <= '0;
      own_end_z_r   <= '0;
      own_radius_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ccot_pkg::CFG_OWN_START_X: own_start_x_r <= cfg_wdata;
        ccot_pkg::CFG_OWN_START_Y: own_start_y_r <= cfg_wdata;
        ccot_pkg::CFG_OWN_START_Z: own_start_z_r <= cfg_wdata;
        ccot_pkg::CFG_OWN_END_X:   own_end_x_r   <= cfg_wdata;
        ccot_pkg::CFG_OWN_END_Y:   own_end_y_r   <= cfg_wdata;
        ccot_pkg::CFG_OWN_END_Z:   own_end_z_r   <= cfg_wdata;
        ccot_pkg::CFG_OWN_RADIUS:  own_radius_r  <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 1: axis vectors and offset
  logic signed [15:0] p1 [3];
  logic signed [15:0] q1 [3];
  logic signed [15:0] p2 [3];
  logic signed [15:0] q2 [3];

  assign p1[0] = in_word.other_start_x;
  assign p1[1] = in_word.other_start_y;
  assign p1[2] = in_word.other_start_z;
  assign q1[0] = in_word.other_end_x;
  assign q1[1] = in_word.other_end_y;
  assign q1[2] = in_word.other_end_z;
  assign p2[0] = own_start_x_r;
  assign p2[1] = own_start_y_r;
  assign p2[2] = own_start_z_r;
  assign q2[0] = own_end_x_r;
  assign q2[1] = own_end_y_r;
  assign q2[2] = own_end_z_r;

  logic               v1_r;
  logic signed [16:0] d1_1r [3];
  logic signed [16:0] d2_1r [3];
  logic signed [16:0] r_1r [3];
  logic [15:0]        rs_1r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
    for (int k = 0; k < 3; k++) begin
      d1_1r[k] <= $signed({q1[k][15], q1[k]}) - $signed({p1[k][15], p1[k]});
      d2_1r[k] <= $signed({q2[k][15], q2[k]}) - $signed({p2[k][15], p2[k]});
      r_1r[k]  <= $signed({p1[k][15], p1[k]}) - $signed({p2[k][15], p2[k]});
    end
    rs_1r <= {1'b0, in_word.other_radius} + {1'b0, own_radius_r};
  end

  // stage 2: component products
  logic               v2_r;
  logic signed [33:0] aa_2r [3];
  logic signed [33:0] ee_2r [3];
  logic signed [33:0] ff_2r [3];
  logic signed [33:0] cc_2r [3];
  logic signed [33:0] bb_2r [3];
  logic signed [16:0] d1_2r [3];
  logic signed [16:0] d2_2r [3];
  logic signed [16:0] r_2r [3];
  logic [15:0]        rs_2r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    for (int k = 0; k < 3; k++) begin
      aa_2r[k] <= d1_1r[k] * d1_1r[k];
      ee_2r[k] <= d2_1r[k] * d2_1r[k];
      ff_2r[k] <= d2_1r[k] * r_1r[k];
      cc_2r[k] <= d1_1r[k] * r_1r[k];
      bb_2r[k] <= d1_1r[k] * d2_1r[k];
      d1_2r[k] <= d1_1r[k];
      d2_2r[k] <= d2_1r[k];
      r_2r[k]  <= r_1r[k];
    end
    rs_2r <= rs_1r;
  end

  // stage 3: dot products
  logic signed [35:0] sum_a, sum_e, sum_b, sum_c, sum_f;
  item_t              s3_nxt;
  item_t              s3_r;

  assign sum_a = aa_2r[0] + aa_2r[1] + aa_2r[2];
  assign sum_e = ee_2r[0] + ee_2r[1] + ee_2r[2];
  assign sum_b = bb_2r[0] + bb_2r[1] + bb_2r[2];
  assign sum_c = cc_2r[0] + cc_2r[1] + cc_2r[2];
  assign sum_f = ff_2r[0] + ff_2r[1] + ff_2r[2];

  always_comb begin
    s3_nxt       = '0;
    s3_nxt.valid = v2_r;
    for (int k = 0; k < 3; k++) begin
      s3_nxt.d1[k] = d1_2r[k];
      s3_nxt.d2[k] = d2_2r[k];
      s3_nxt.r[k]  = r_2r[k];
    end
    s3_nxt.rs = rs_2r;
    s3_nxt.a  = sum_a[33:0];
    s3_nxt.e  = sum_e[33:0];
    s3_nxt.b  = sum_b;
    s3_nxt.c  = sum_c;
    s3_nxt.f  = sum_f;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.valid <= 1'b0;
    end else begin
      s3_r <= s3_nxt;
    end
  end

  // stage 4: wide products for the general solve
  item_t              s4_r;
  logic signed [71:0] ae_4r, bsq_4r, bf_4r, ce_4r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_r.valid <= 1'b0;
    end else begin
      s4_r <= s3_r;
    end
    ae_4r  <= $signed({2'b00, s3_r.a}) * $signed({2'b00, s3_r.e});
    bsq_4r <= $signed(s3_r.b) * $signed(s3_r.b);
    bf_4r  <= $signed(s3_r.b) * $signed(s3_r.f);
    ce_4r  <= $signed(s3_r.c) * $signed({2'b00, s3_r.e});
  end

  // stage 5: numerator, denominator and early clamp
  logic signed [71:0] den5, num5;
  item_t              s5_nxt;
  item_t              s5_r;
  logic [68:0]        rem5_r, den5_r;

  assign den5 = ae_4r - bsq_4r;
  assign num5 = bf_4r - ce_4r;

  always_comb begin
    s5_nxt       = s4_r;
    s5_nxt.s_div = 1'b0;
    s5_nxt.s_val = '0;
    if (s4_r.a != '0 && s4_r.e != '0 && den5 > 0 && num5 > 0) begin
      if (num5 >= den5) begin
        s5_nxt.s_val = ccot_pkg::FRAC_ONE;
      end else begin
        s5_nxt.s_div = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_r.valid <= 1'b0;
    end else begin
      s5_r <= s5_nxt;
    end
    rem5_r <= num5[68:0];
    den5_r <= den5[68:0];
  end

  // general s divider
  logic [FW-1:0] q_gen;
  item_t         sd1_r [FW];

  ccot_div #(.W(69), .STEPS(FW)) u_div_gen (
    .clk   (clk),
    .rem_i (rem5_r),
    .low_i ({FW{1'b0}}),
    .den_i (den5_r),
    .quo_o (q_gen)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < FW; j++) sd1_r[j].valid <= 1'b0;
    end else begin
      sd1_r[0] <= s5_r;
      for (int j = 1; j < FW; j++) sd1_r[j] <= sd1_r[j-1];
    end
  end

  // stage 6: numerator of t
  logic [FW:0]        s_gen;
  item_t              s6_nxt;
  item_t              s6_r;
  logic signed [54:0] tnom_6r;

  assign s_gen = sd1_r[FW-1].s_div ? {1'b0, q_gen} : sd1_r[FW-1].s_val;

  always_comb begin
    s6_nxt       = sd1_r[FW-1];
    s6_nxt.s_val = s_gen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_r.valid <= 1'b0;
    end else begin
      s6_r <= s6_nxt;
    end
    tnom_6r <= $signed(sd1_r[FW-1].b) * $signed({1'b0, s_gen})
             + $signed({sd1_r[FW-1].f, {FW{1'b0}}});
  end

  // stage 7: case split, clamps and divider operands
  logic signed [54:0] e_one;
  logic signed [36:0] ns, nt;
  logic signed [36:0] a_ext, e_ext;
  logic               use_s, use_t;
  item_t              s7_nxt;
  item_t              s7_r;
  logic [34:0]        rem_s_nxt, rem_t_nxt;
  logic [FW-1:0]      low_t_nxt;
  logic [34:0]        rem_s_7r, rem_t_7r;
  logic [FW-1:0]      low_t_7r;

  assign e_one = $signed({5'b00000, s6_r.e, {FW{1'b0}}});
  assign a_ext = $signed({3'b000, s6_r.a});
  assign e_ext = $signed({3'b000, s6_r.e});

  always_comb begin
    s7_nxt       = s6_r;
    s7_nxt.s_div = 1'b0;
    s7_nxt.t_div = 1'b0;
    s7_nxt.t_val = '0;
    rem_s_nxt    = '0;
    rem_t_nxt    = '0;
    low_t_nxt    = '0;
    use_s        = 1'b0;
    use_t        = 1'b0;
    ns           = -$signed({s6_r.c[35], s6_r.c});
    nt           = $signed({s6_r.f[35], s6_r.f});
    if (s6_r.a == '0 && s6_r.e == '0) begin
      s7_nxt.s_val = '0;
    end else if (s6_r.a == '0) begin
      s7_nxt.s_val = '0;
      use_t        = 1'b1;
    end else if (s6_r.e == '0) begin
      use_s = 1'b1;
    end else if (tnom_6r < 0) begin
      use_s = 1'b1;
    end else if (tnom_6r > e_one) begin
      s7_nxt.t_val = ccot_pkg::FRAC_ONE;
      use_s        = 1'b1;
      ns           = $signed({s6_r.b[35], s6_r.b}) - $signed({s6_r.c[35], s6_r.c});
    end else if (tnom_6r == e_one) begin
      s7_nxt.t_val = ccot_pkg::FRAC_ONE;
    end else begin
      s7_nxt.t_div = 1'b1;
      rem_t_nxt    = {1'b0, tnom_6r[49:FW]};
      low_t_nxt    = tnom_6r[FW-1:0];
    end
    if (use_s) begin
      if (ns <= 0) begin
        s7_nxt.s_val = '0;
      end else if (ns >= a_ext) begin
        s7_nxt.s_val = ccot_pkg::FRAC_ONE;
      end else begin
        s7_nxt.s_div = 1'b1;
        rem_s_nxt    = ns[34:0];
      end
    end
    if (use_t) begin
      if (nt <= 0) begin
        s7_nxt.t_val = '0;
      end else if (nt >= e_ext) begin
        s7_nxt.t_val = ccot_pkg::FRAC_ONE;
      end else begin
        s7_nxt.t_div = 1'b1;
        rem_t_nxt    = nt[34:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_r.valid <= 1'b0;
    end else begin
      s7_r <= s7_nxt;
    end
    rem_s_7r <= rem_s_nxt;
    rem_t_7r <= rem_t_nxt;
    low_t_7r <= low_t_nxt;
  end

  // recompute dividers
  logic [FW-1:0] q_s, q_t;
  item_t         sd2_r [FW];

  ccot_div #(.W(35), .STEPS(FW)) u_div_s (
    .clk   (clk),
    .rem_i (rem_s_7r),
    .low_i ({FW{1'b0}}),
    .den_i ({1'b0, s7_r.a}),
    .quo_o (q_s)
  );

  ccot_div #(.W(35), .STEPS(FW)) u_div_t (
    .clk   (clk),
    .rem_i (rem_t_7r),
    .low_i (low_t_7r),
    .den_i ({1'b0, s7_r.e}),
    .quo_o (q_t)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < FW; j++) sd2_r[j].valid <= 1'b0;
    end else begin
      sd2_r[0] <= s7_r;
      for (int j = 1; j < FW; j++) sd2_r[j] <= sd2_r[j-1];
    end
  end

  // stage 8: closest point offsets
  logic [FW:0]        s_fin, t_fin;
  logic               v8_r;
  logic signed [34:0] ps_8r [3];
  logic signed [34:0] pt_8r [3];
  logic signed [16:0] r_8r [3];
  logic [15:0]        rs_8r;
  logic [FW:0]        s_8r, t_8r;

  assign s_fin = sd2_r[FW-1].s_div ? {1'b0, q_s} : sd2_r[FW-1].s_val;
  assign t_fin = sd2_r[FW-1].t_div ? {1'b0, q_t} : sd2_r[FW-1].t_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else begin
      v8_r <= sd2_r[FW-1].valid;
    end
    for (int k = 0; k < 3; k++) begin
      ps_8r[k] <= $signed(sd2_r[FW-1].d1[k]) * $signed({1'b0, s_fin});
      pt_8r[k] <= $signed(sd2_r[FW-1].d2[k]) * $signed({1'b0, t_fin});
      r_8r[k]  <= $signed(sd2_r[FW-1].r[k]);
    end
    rs_8r <= sd2_r[FW-1].rs;
    s_8r  <= s_fin;
    t_8r  <= t_fin;
  end

  // stage 9: truncate toward zero and form differences
  logic signed [35:0] ps_adj [3];
  logic signed [35:0] pt_adj [3];
  logic               v9_r;
  logic signed [20:0] dk_9r [3];
  logic [15:0]        rs_9r;
  logic [FW:0]        s_9r, t_9r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ps_adj[k] = $signed({ps_8r[k][34], ps_8r[k]})
                + (ps_8r[k][34] ? $signed({20'd0, {FW{1'b1}}}) : 36'sd0);
      pt_adj[k] = $signed({pt_8r[k][34], pt_8r[k]})
                + (pt_8r[k][34] ? $signed({20'd0, {FW{1'b1}}}) : 36'sd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else begin
      v9_r <= v8_r;
    end
    for (int k = 0; k < 3; k++) begin
      dk_9r[k] <= $signed({{4{r_8r[k][16]}}, r_8r[k]})
                + $signed({ps_adj[k][35], ps_adj[k][35:FW]})
                - $signed({pt_adj[k][35], pt_adj[k][35:FW]});
    end
    rs_9r <= rs_8r;
    s_9r  <= s_8r;
    t_9r  <= t_8r;
  end

  // stage 10: squares
  logic               v10_r;
  logic signed [41:0] sq_10r [3];
  logic [31:0]        rsq_10r;
  logic [FW:0]        s_10r, t_10r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v10_r <= 1'b0;
    end else begin
      v10_r <= v9_r;
    end
    for (int k = 0; k < 3; k++) begin
      sq_10r[k] <= dk_9r[k] * dk_9r[k];
    end
    rsq_10r <= rs_9r * rs_9r;
    s_10r   <= s_9r;
    t_10r   <= t_9r;
  end

  // stage 11: distance and hit
  logic [43:0]         dist_sum;
  logic                out_valid_r;
  ccot_pkg::out_word_t out_word_r;

  assign dist_sum = {2'b00, sq_10r[0]} + {2'b00, sq_10r[1]} + {2'b00, sq_10r[2]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v10_r;
    end
    out_word_r.hit        <= (dist_sum <= {12'd0, rsq_10r});
    out_word_r.dist_sq    <= dist_sum[ccot_pkg::DIST_W-1:0];
    out_word_r.frac_other <= s_10r;
    out_word_r.frac_own   <= t_10r;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `CCOT_ASSERT_IMP(a_latency, start && !busy, ##LATENCY out_valid)
  `CCOT_ASSERT_IMP(a_frac_range, out_valid, out_word.frac_other <= ccot_pkg::FRAC_ONE && out_word.frac_own <= ccot_pkg::FRAC_ONE)
  `CCOT_ASSERT_IMP(a_hit_range, out_valid && out_word.hit, out_word.dist_sq[ccot_pkg::DIST_W-1:32] == '0)
  `CCOT_ASSERT(a_div_case, s7_r.valid && s7_r.t_div |-> s7_r.e != '0)

endmodule
